@@ hw/rtl/lz78td_pkg.sv @@
// Shared constants, field widths and the controller/datapath command and status
// structures of the LZ78 token decoder. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lz78td_pkg;

   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 8;
   localparam int LEN_W       = 8;
   localparam int COUNT_W     = 3;
   localparam int GROUP_BYTES = 4;
   localparam int LANE_W      = 2;
   localparam int STACK_DEPTH = 256;
   localparam int STACK_AW    = 8;
   // Read and capture pointers must hold the phrase length plus one group.
   localparam int PTR_W       = 9;

   typedef enum logic {
      DADDR_PIDX,
      DADDR_PARENT
   } dict_addr_sel_type;

   typedef struct packed {
      logic              load_token;
      logic              set_bad;
      logic              clear_prefix;
      logic              head_load;
      logic              walk_step;
      dict_addr_sel_type dict_addr;
      logic              append;
      logic              fill;
      logic              next_group;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bad_prefix;
      logic prefix_zero;
      logic walk_done;
      logic group_done;
      logic last_group;
   } ctrl_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/lz78td_req_if.sv @@
// Token channel of the LZ78 token decoder: valid/ready handshake and token fields.
// Depends on lz78td_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lz78td_req_if;
   import lz78td_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] prefix_index;
   logic [BYTE_W-1:0]  literal_byte;
   logic               final_token;

   modport source (output valid, prefix_index, literal_byte, final_token, input ready);
   modport sink (input valid, prefix_index, literal_byte, final_token, output ready);
   modport monitor (input valid, ready, prefix_index, literal_byte, final_token);
endinterface

`default_nettype wire

@@ hw/rtl/lz78td_rsp_if.sv @@
// Byte-group channel of the LZ78 token decoder: valid/ready handshake and group fields.
// Depends on lz78td_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lz78td_rsp_if;
   import lz78td_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte_a;
   logic [BYTE_W-1:0]  out_byte_b;
   logic [BYTE_W-1:0]  out_byte_c;
   logic [BYTE_W-1:0]  out_byte_d;
   logic [COUNT_W-1:0] byte_count;
   logic               last_group;
   logic               bad_index;

   modport source (output valid, out_byte_a, out_byte_b, out_byte_c, out_byte_d,
                   byte_count, last_group, bad_index, input ready);
   modport sink (input valid, out_byte_a, out_byte_b, out_byte_c, out_byte_d,
                 byte_count, last_group, bad_index, output ready);
   modport monitor (input valid, ready, out_byte_a, out_byte_b, out_byte_c, out_byte_d,
                    byte_count, last_group, bad_index);
endinterface

`default_nettype wire

@@ hw/rtl/lz78td_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module lz78td_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lz78td_ctrl.sv @@
// Sequencer of the LZ78 token decoder: checks the index, walks the parent chain,
// stores the new entry and hands out the phrase group by group. Depends on lz78td_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lz78td_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire lz78td_pkg::ctrl_sts_type sts,
   output lz78td_pkg::ctrl_cmd_type     cmd
);
   import lz78td_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_HEAD   = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_APPEND = 3'd4;
   localparam logic [2:0] ST_FILL   = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_token = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // The prefix entry is read here so that it is ready in the head state.
            cmd.dict_addr = DADDR_PIDX;
            if (sts.bad_prefix) begin
               cmd.set_bad = 1'b1;
               state_in    = ST_OUT;
            end else if (sts.prefix_zero) begin
               cmd.clear_prefix = 1'b1;
               state_in         = ST_APPEND;
            end else begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.dict_addr = DADDR_PIDX;
            cmd.head_load = 1'b1;
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            if (sts.walk_done) begin
               state_in = ST_APPEND;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.dict_addr = DADDR_PARENT;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (sts.group_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.next_group = 1'b1;
               state_in       = sts.last_group ? ST_IDLE : ST_FILL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/lz78td_dpath.sv @@
// Datapath of the LZ78 token decoder: dictionary and phrase stack memories, token,
// walk and group registers. Depends on lz78td_pkg and lz78td_ram.
`timescale 1ns / 1ps
`default_nettype none

module lz78td_dpath #(
   parameter int DICT_ENTRIES = 255
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lz78td_pkg::ctrl_cmd_type            cmd,
   output lz78td_pkg::ctrl_sts_type                 sts,
   input  wire logic [lz78td_pkg::INDEX_W-1:0]      prefix_index,
   input  wire logic [lz78td_pkg::BYTE_W-1:0]       literal_byte,
   input  wire logic                                final_token,
   output logic      [lz78td_pkg::BYTE_W-1:0]       out_byte_a,
   output logic      [lz78td_pkg::BYTE_W-1:0]       out_byte_b,
   output logic      [lz78td_pkg::BYTE_W-1:0]       out_byte_c,
   output logic      [lz78td_pkg::BYTE_W-1:0]       out_byte_d,
   output logic      [lz78td_pkg::COUNT_W-1:0]      byte_count,
   output logic                                     last_group,
   output logic                                     bad_index
);
   import lz78td_pkg::*;

   localparam int DICT_AW     = $clog2(DICT_ENTRIES);
   localparam int ENTRY_CNT_W = $clog2(DICT_ENTRIES + 1);
   // Dictionary word: parent index, last byte, phrase length.
   localparam int ENTRY_W     = DICT_AW + BYTE_W + LEN_W;

   logic [INDEX_W-1:0]     pidx_ff, pidx_in;
   logic [BYTE_W-1:0]      lit_ff, lit_in;
   logic                   drop_ff, drop_in;
   logic [ENTRY_CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]       plen_ff, plen_in;
   logic [LEN_W-1:0]       walk_ff, walk_in;
   logic [ENTRY_W-1:0]     head_ff, head_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]       cap_ff, cap_in;
   logic [PTR_W-1:0]       base_ff, base_in;
   logic                   pend_ff, pend_in;
   logic                   bad_ff, bad_in;
   logic [BYTE_W-1:0]      grp_ff [GROUP_BYTES];
   logic [BYTE_W-1:0]      grp_in [GROUP_BYTES];

   logic [ENTRY_W-1:0]     dict_rd;
   logic [ENTRY_W-1:0]     dict_wr;
   logic [DICT_AW-1:0]     dict_rd_addr;
   logic                   dict_wr_en;
   logic [DICT_AW-1:0]     rd_parent;
   logic [BYTE_W-1:0]      rd_byte;
   logic [LEN_W-1:0]       rd_len;
   logic                   dict_room;
   logic [LEN_W-1:0]       new_len;

   logic                   stack_wr_en;
   logic [STACK_AW-1:0]    stack_wr_addr;
   logic [BYTE_W-1:0]      stack_wr_data;
   logic [BYTE_W-1:0]      stack_rd;

   logic [PTR_W-1:0]       len_ext;
   logic [PTR_W-1:0]       base_next;
   logic [PTR_W-1:0]       grp_end;
   logic                   issue_ok;

   assign rd_parent = dict_rd[ENTRY_W-1 -: DICT_AW];
   assign rd_byte   = dict_rd[BYTE_W+LEN_W-1 -: BYTE_W];
   assign rd_len    = dict_rd[LEN_W-1:0];

   assign dict_room = count_ff < ENTRY_CNT_W'(DICT_ENTRIES);
   assign new_len   = plen_ff + {{(LEN_W-1){1'b0}}, ~drop_ff};

   // A dropped literal stores a copy of the prefix entry; the head register holds
   // zeros when the prefix is the empty entry.
   assign dict_wr      = drop_ff ? head_ff : {pidx_ff[DICT_AW-1:0], lit_ff, new_len};
   assign dict_wr_en   = cmd.append && dict_room;
   assign dict_rd_addr = (cmd.dict_addr == DADDR_PARENT) ? rd_parent
                                                         : pidx_ff[DICT_AW-1:0];

   lz78td_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DICT_ENTRIES)
   ) u_dict_ram (
      .clock   (clock),
      .wr_en   (dict_wr_en),
      .wr_addr (count_ff[DICT_AW-1:0]),
      .wr_data (dict_wr),
      .rd_addr (dict_rd_addr),
      .rd_data (dict_rd)
   );

   // The walk fills the stack from the end of the prefix backwards.
   assign stack_wr_en   = cmd.walk_step || (cmd.append && !drop_ff);
   assign stack_wr_addr = cmd.walk_step ? STACK_AW'(walk_ff - LEN_W'(1)) : STACK_AW'(plen_ff);
   assign stack_wr_data = cmd.walk_step ? rd_byte : lit_ff;

   lz78td_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_addr (rd_ptr_ff[STACK_AW-1:0]),
      .rd_data (stack_rd)
   );

   assign len_ext   = PTR_W'(len_ff);
   assign base_next = base_ff + PTR_W'(GROUP_BYTES);
   assign grp_end   = (len_ext < base_next) ? len_ext : base_next;
   assign issue_ok  = rd_ptr_ff < grp_end;

   assign sts.bad_prefix  = pidx_ff >= INDEX_W'(count_ff);
   assign sts.prefix_zero = pidx_ff == '0;
   assign sts.walk_done   = walk_ff == '0;
   assign sts.group_done  = !pend_ff && (cap_ff == grp_end);
   assign sts.last_group  = cap_ff == len_ext;

   always_comb begin
      pidx_in   = pidx_ff;
      lit_in    = lit_ff;
      drop_in   = drop_ff;
      count_in  = count_ff;
      plen_in   = plen_ff;
      walk_in   = walk_ff;
      head_in   = head_ff;
      len_in    = len_ff;
      rd_ptr_in = rd_ptr_ff;
      cap_in    = cap_ff;
      base_in   = base_ff;
      bad_in    = bad_ff;
      grp_in    = grp_ff;
      pend_in   = cmd.fill && issue_ok;

      if (cmd.load_token) begin
         pidx_in = prefix_index;
         lit_in  = literal_byte;
         drop_in = final_token && (literal_byte == '0);
      end
      if (cmd.set_bad || cmd.append) begin
         bad_in    = cmd.set_bad;
         len_in    = cmd.set_bad ? '0 : new_len;
         rd_ptr_in = '0;
         cap_in    = '0;
         base_in   = '0;
         grp_in    = '{default: '0};
      end
      if (cmd.append && dict_room) begin
         count_in = count_ff + ENTRY_CNT_W'(1);
      end
      if (cmd.clear_prefix) begin
         plen_in = '0;
         walk_in = '0;
         head_in = '0;
      end
      if (cmd.head_load) begin
         plen_in = rd_len;
         walk_in = rd_len;
         head_in = dict_rd;
      end
      if (cmd.walk_step) begin
         walk_in = walk_ff - LEN_W'(1);
      end
      if (cmd.fill && issue_ok) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      // Stack data arrives in the cycle after its address was issued.
      if (pend_ff) begin
         grp_in[cap_ff[LANE_W-1:0]] = stack_rd;
         cap_in                     = cap_ff + PTR_W'(1);
      end
      if (cmd.next_group) begin
         base_in = cap_ff;
         grp_in  = '{default: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ENTRY_CNT_W'(1);
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      pidx_ff   <= pidx_in;
      lit_ff    <= lit_in;
      drop_ff   <= drop_in;
      plen_ff   <= plen_in;
      walk_ff   <= walk_in;
      head_ff   <= head_in;
      len_ff    <= len_in;
      rd_ptr_ff <= rd_ptr_in;
      cap_ff    <= cap_in;
      base_ff   <= base_in;
      bad_ff    <= bad_in;
      grp_ff    <= grp_in;
   end

   assign out_byte_a = grp_ff[0];
   assign out_byte_b = grp_ff[1];
   assign out_byte_c = grp_ff[2];
   assign out_byte_d = grp_ff[3];
   assign byte_count = COUNT_W'(cap_ff - base_ff);
   assign last_group = sts.last_group;
   assign bad_index  = bad_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lz78_token_decoder_core.sv @@
// LZ78 token decoder, top level. Depends on lz78td_pkg, the two channel interfaces,
// lz78td_ctrl and lz78td_dpath.
//
// A token (prefix index, literal byte, final flag) enters on req_chan; its phrase
// leaves on rsp_chan as groups of up to four bytes, the last group flagged. Tokens
// are handled one at a time: req_chan.ready is high only while the block is idle.
// An empty prefix skips the head and walk states. The parent chain is walked one
// dictionary read per cycle, and the phrase is read back from the stack memory one
// byte per cycle within each group.
// A bad index gives a single flagged empty group straight from the check state.
// Each group is held in registers and stays on rsp_chan until it is taken; the
// block simply waits while the receiver stalls.
// Reset empties the dictionary (entry count back to one) and returns to idle; the
// memories need no clearing, since only entries below the count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module lz78_token_decoder_core #(
   parameter int DICT_ENTRIES = 255
) (
   input wire logic     clock,
   input wire logic     reset,
   lz78td_req_if.sink   req_chan,
   lz78td_rsp_if.source rsp_chan
);
   import lz78td_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   lz78td_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lz78td_dpath #(
      .DICT_ENTRIES (DICT_ENTRIES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .prefix_index (req_chan.prefix_index),
      .literal_byte (req_chan.literal_byte),
      .final_token  (req_chan.final_token),
      .out_byte_a   (rsp_chan.out_byte_a),
      .out_byte_b   (rsp_chan.out_byte_b),
      .out_byte_c   (rsp_chan.out_byte_c),
      .out_byte_d   (rsp_chan.out_byte_d),
      .byte_count   (rsp_chan.byte_count),
      .last_group   (rsp_chan.last_group),
      .bad_index    (rsp_chan.bad_index)
   );

endmodule

`default_nettype wire

@@ hw/rtl/lz78td_checker.sv @@
// Port-level checks of the LZ78 token decoder and the bind that attaches them to
// the top level. Depends on lz78td_pkg and lz78_token_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

module lz78td_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [lz78td_pkg::COUNT_W-1:0] rsp_byte_count,
   input wire logic                          rsp_last_group,
   input wire logic                          rsp_bad_index
);
   import lz78td_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result group withdrawn before it was taken.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Token taken while the previous one is still in work.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Token channel ready while a group is on offer.");

   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |->
         rsp_byte_count == '0 && rsp_last_group)
      else $error("Bad index group is not a single empty group.");

   a_full_groups: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_group |->
         rsp_byte_count == COUNT_W'(GROUP_BYTES))
      else $error("Group other than the last one is not full.");

endmodule

bind lz78_token_decoder_core lz78td_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_byte_count (rsp_chan.byte_count),
   .rsp_last_group (rsp_chan.last_group),
   .rsp_bad_index  (rsp_chan.bad_index)
);

`default_nettype wire
